### hdl/dltq_pkg.sv
// Package for the delta-list timer queue: sizes, codes and the records
// passed between the controller and the row of list cells.
// No dependencies.
package dltq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DELTA_W = 16;
    localparam int OWNER_W = 8;
    localparam int TPS_W   = 8;

    localparam logic [TPS_W-1:0] TPS_RESET = 8'd60;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_WAKE   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP,
        ST_DEC,
        ST_POP
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_WALK,
        OP_SHIFT,
        OP_DEC
    } cell_op_t;

    typedef struct packed {
        logic               valid;
        logic [DELTA_W-1:0] delta;
        logic [OWNER_W-1:0] owner;
    } entry_t;

    // search = 1: new sleeper looking for its slot, delta is remaining time
    // search = 0: displaced entry being pushed toward the tail
    typedef struct packed {
        logic               valid;
        logic               search;
        logic [DELTA_W-1:0] delta;
        logic [OWNER_W-1:0] owner;
    } token_t;

endpackage

### hdl/dltq_cell.sv
// One list position of the delta-list timer queue: holds an entry and a
// token register that hands insert traffic to the next position.
// Depends on dltq_pkg.
module dltq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  dltq_pkg::cell_op_t op,
    input  dltq_pkg::token_t  tok_in,
    input  dltq_pkg::entry_t  right_in,
    output dltq_pkg::entry_t  ent,
    output dltq_pkg::token_t  tok_out
);
    import dltq_pkg::*;

    entry_t ent_reg, ent_next;
    token_t tok_reg, tok_next;

    always_comb
    begin
        ent_next = ent_reg;
        tok_next = '0;
        case (op)
            OP_WALK:
            begin
                if (tok_in.valid)
                begin
                    if (!ent_reg.valid)
                    begin
                        ent_next.valid = 1'b1;
                        ent_next.delta = tok_in.delta;
                        ent_next.owner = tok_in.owner;
                    end
                    else if (tok_in.search && (tok_in.delta >= ent_reg.delta))
                    begin
                        tok_next       = tok_in;
                        tok_next.delta = tok_in.delta - ent_reg.delta;
                    end
                    else
                    begin
                        ent_next.delta  = tok_in.delta;
                        ent_next.owner  = tok_in.owner;
                        tok_next.valid  = 1'b1;
                        tok_next.search = 1'b0;
                        tok_next.owner  = ent_reg.owner;
                        tok_next.delta  = tok_in.search ? (ent_reg.delta - tok_in.delta)
                                                        : ent_reg.delta;
                    end
                end
            end
            OP_SHIFT:
            begin
                ent_next = right_in;
            end
            OP_DEC:
            begin
                if (ent_reg.delta != '0)
                begin
                    ent_next.delta = ent_reg.delta - 1'b1;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
            tok_reg <= tok_next;
        end
    end

    assign ent     = ent_reg;
    assign tok_out = tok_reg;

endmodule

### hdl/delta_list_timer_queue_unit.sv
// Top level of the delta-list timer queue: controller, prescaler, result
// register and the row of dltq_cell list positions.
// Depends on dltq_pkg and dltq_cell.
//
// Usage:
//   Input beats (mode, duration, process_id) on in_valid/in_ready. mode 1
//   inserts a sleeper; mode 0 is one timer tick. Result beats (kind,
//   owner_id, last) leave on out_valid/out_ready through a result register.
//   The user must write ticks_per_second on cfg_valid/cfg_ready only
//   while idle; cfg_ready is tied high, so the block leaves this to the
//   user. An insert walks its token down the cells one position per
//   cycle until its walk count runs out, then its one result is loaded,
//   and only then is the next beat taken. A full queue skips the walk.
//   A tick without a second only steps the prescaler; at a second the
//   head is decremented, then each woken entry is sent as the row shifts
//   toward the head; a second that wakes nothing only checks the head.
//   While the receiver stalls, the pending result holds and the block
//   waits; input is taken only when the controller is idle.
//   Reset empties the queue at once (cell valid bits clear), zeroes the
//   prescaler and sets ticks_per_second to 60.
module delta_list_timer_queue_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic [dltq_pkg::DELTA_W-1:0] duration,
    input  logic [dltq_pkg::OWNER_W-1:0] process_id,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [dltq_pkg::OWNER_W-1:0] owner_id,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dltq_pkg::TPS_W-1:0]   ticks_per_second
);
    import dltq_pkg::*;

    state_t             state_reg, state_next;
    logic [TPS_W-1:0]   tps_reg;
    logic [TPS_W-1:0]   presc_reg, presc_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   walk_cnt_reg, walk_cnt_next;
    kind_t              resp_kind_reg, resp_kind_next;
    logic [OWNER_W-1:0] pid_reg;
    token_t             inj_reg, inj_next;

    logic               out_valid_reg, out_valid_next;
    kind_t              kind_reg, kind_next;
    logic [OWNER_W-1:0] owner_reg, owner_next;
    logic               last_reg, last_next;

    cell_op_t           row_op;
    cell_op_t           cell_op [DEPTH];
    entry_t             ent     [DEPTH];
    token_t             tok     [DEPTH];

    logic               accept;
    logic               out_free;
    logic               second;
    logic [TPS_W-1:0]   presc_inc;
    logic               full;
    logic               head_wake;
    logic               pop_last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign presc_inc = presc_reg + 1'b1;
    assign second    = (tps_reg == '0) ? (presc_inc == '0) : (presc_inc >= tps_reg);
    assign full      = (used_reg == CNT_W'(DEPTH));
    assign head_wake = ent[0].valid && (ent[0].delta == '0);
    assign pop_last  = !(ent[1].valid && (ent[1].delta == '0));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        state_next = full ? ST_RESP : ST_WALK;
                    end
                    else if (second && (used_reg != '0))
                    begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_WALK:
            begin
                if (walk_cnt_reg == '0)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEC:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (!head_wake)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free && pop_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        presc_next     = presc_reg;
        used_next      = used_reg;
        walk_cnt_next  = walk_cnt_reg;
        resp_kind_next = resp_kind_reg;
        inj_next       = '0;
        row_op         = OP_HOLD;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        owner_next     = owner_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        resp_kind_next = full ? KIND_FULL : KIND_ACCEPT;
                        walk_cnt_next  = used_reg;
                        if (!full)
                        begin
                            inj_next.valid  = 1'b1;
                            inj_next.search = 1'b1;
                            inj_next.delta  = duration;
                            inj_next.owner  = process_id;
                        end
                    end
                    else
                    begin
                        presc_next = second ? '0 : presc_inc;
                    end
                end
            end
            ST_WALK:
            begin
                row_op = OP_WALK;
                if (walk_cnt_reg == '0)
                begin
                    used_next = used_reg + 1'b1;
                end
                else
                begin
                    walk_cnt_next = walk_cnt_reg - 1'b1;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = resp_kind_reg;
                    owner_next     = pid_reg;
                    last_next      = 1'b1;
                end
            end
            ST_DEC:
            begin
                row_op = OP_DEC;
            end
            ST_POP:
            begin
                if (head_wake && out_free)
                begin
                    row_op         = OP_SHIFT;
                    used_next      = used_reg - 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = KIND_WAKE;
                    owner_next     = ent[0].owner;
                    last_next      = pop_last;
                end
            end
            default:
            begin
                row_op = OP_HOLD;
            end
        endcase
    end

    // decrement reaches the head only
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_op[i] = ((row_op == OP_DEC) && (i != 0)) ? OP_HOLD : row_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tps_reg       <= TPS_RESET;
            presc_reg     <= '0;
            used_reg      <= '0;
            walk_cnt_reg  <= '0;
            inj_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            presc_reg     <= presc_next;
            used_reg      <= used_next;
            walk_cnt_reg  <= walk_cnt_next;
            inj_reg       <= inj_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                tps_reg <= ticks_per_second;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        resp_kind_reg  <= resp_kind_next;
        kind_reg       <= kind_next;
        owner_reg      <= owner_next;
        last_reg       <= last_next;
        if (accept)
        begin
            pid_reg <= process_id;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            dltq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .op       (cell_op[g]),
                .tok_in   ((g == 0) ? inj_reg : tok[(g == 0) ? 0 : g - 1]),
                .right_in ((g == DEPTH - 1) ? entry_t'('0)
                                            : ent[(g == DEPTH - 1) ? g : g + 1]),
                .ent      (ent[g]),
                .tok_out  (tok[g])
            );
        end
    endgenerate

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign owner_id  = owner_reg;
    assign last      = last_reg;

endmodule

### bench/delta_list_timer_queue_unit_tb.sv
// Self-checking bench for delta_list_timer_queue_unit: inserts and ticks under several
// prescaler settings, each result beat checked against an in-bench delta-list predictor.
// Depends on dltq_pkg and the delta_list_timer_queue_unit RTL.
module delta_list_timer_queue_unit_tb;
    import dltq_pkg::*;

    localparam int PERIOD       = 12;
    localparam int MAX_WAKES    = 16;
    localparam int SETTLE       = DEPTH + 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 3_000_000;

    typedef enum logic [1:0] {
        JOB_BEAT,
        JOB_CFG,
        JOB_SYNC
    } job_act_t;

    typedef struct {
        job_act_t           act;
        logic               mode;
        logic [DELTA_W-1:0] dur;
        logic [OWNER_W-1:0] pid;
        logic [TPS_W-1:0]   tps;
        int                 gap;
        bit                 hold_rx;
    } job_t;

    typedef struct {
        logic [DELTA_W-1:0] delta;
        logic [OWNER_W-1:0] owner;
    } sleeper_t;

    typedef struct {
        kind_t              kind;
        logic [OWNER_W-1:0] owner;
        logic               last;
    } reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               mode = 1'b0;
    logic [DELTA_W-1:0] duration = '0;
    logic [OWNER_W-1:0] process_id = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         kind;
    logic [OWNER_W-1:0] owner_id;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [TPS_W-1:0]   ticks_per_second = TPS_RESET;

    job_t     jobs[$];
    sleeper_t sleepers[$];
    reply_t   replies_due[$];

    logic [TPS_W-1:0] secs_divisor = TPS_RESET;
    logic [TPS_W-1:0] prescale = '0;

    int errors = 0;
    int calm_jobs = 0;
    int gap_left = 0;
    int cur_gap = 0;
    int quiet = 0;
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;
    int calm_left = 0;

    delta_list_timer_queue_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .duration         (duration),
        .process_id       (process_id),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .owner_id         (owner_id),
        .last             (last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .ticks_per_second (ticks_per_second)
    );

    always
    begin
        #(PERIOD / 2) clk = 1'b1;
        #(PERIOD / 2) clk = 1'b0;
    end

    // delta-list predictor: one accepted input beat in, expected result beats queued
    function automatic void advance_timer_queue(input logic m, input logic [DELTA_W-1:0] d,
                                                input logic [OWNER_W-1:0] p);
        logic [DELTA_W-1:0] rem;
        logic [TPS_W-1:0]   nxt;
        logic               sec;
        int                 pos;
        int                 woke;
        sleeper_t           s;
        reply_t             r;
        if (m) begin
            r.owner = p;
            r.last  = 1'b1;
            if (sleepers.size() >= DEPTH) begin
                r.kind = KIND_FULL;
                replies_due.push_back(r);
                return;
            end
            rem = d;
            pos = 0;
            while (pos < sleepers.size() && rem >= sleepers[pos].delta) begin
                rem = rem - sleepers[pos].delta;
                pos++;
            end
            if (pos < sleepers.size())
                sleepers[pos].delta = sleepers[pos].delta - rem;
            s.delta = rem;
            s.owner = p;
            sleepers.insert(pos, s);
            r.kind = KIND_ACCEPT;
            replies_due.push_back(r);
        end else begin
            nxt = prescale + 8'd1;
            sec = (secs_divisor == '0) ? (nxt == '0) : (nxt >= secs_divisor);
            prescale = sec ? '0 : nxt;
            if (!sec || sleepers.size() == 0)
                return;
            if (sleepers[0].delta != '0)
                sleepers[0].delta = sleepers[0].delta - 16'd1;
            woke = 0;
            while (sleepers.size() > 0 && woke < MAX_WAKES && sleepers[0].delta == '0) begin
                r.kind  = KIND_WAKE;
                r.owner = sleepers[0].owner;
                r.last  = 1'b0;
                replies_due.push_back(r);
                void'(sleepers.pop_front());
                woke++;
            end
            if (woke > 0)
                replies_due[replies_due.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic int idle_span();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap();
        if (calm_jobs > 0) begin
            calm_jobs--;
            return 0;
        end
        if ($urandom_range(0, 99) < 4) begin
            calm_jobs = $urandom_range(10, 30);
            return 0;
        end
        return ($urandom_range(0, 99) < 40) ? idle_span() : 0;
    endfunction

    function automatic void put_job(input job_act_t act, input logic m,
                                    input logic [DELTA_W-1:0] d, input logic [OWNER_W-1:0] p,
                                    input logic [TPS_W-1:0] v);
        job_t j;
        j.act     = act;
        j.mode    = m;
        j.dur     = d;
        j.pid     = p;
        j.tps     = v;
        j.gap     = sender_gap();
        j.hold_rx = 1'b0;
        jobs.push_back(j);
    endfunction

    function automatic void put_ticks(input int n);
        for (int i = 0; i < n; i++)
            put_job(JOB_BEAT, 1'b0, DELTA_W'($urandom), OWNER_W'($urandom), '0);
    endfunction

    function automatic void plan_phase(input logic [TPS_W-1:0] v, input int n_ins,
                                       input int n_tick, input int dur_max);
        logic [DELTA_W-1:0] d;
        put_job(JOB_CFG, 1'b0, '0, '0, v);
        while (n_ins > 0 || n_tick > 0) begin
            if (n_ins > 0 && (n_tick == 0 || $urandom_range(0, n_ins + n_tick - 1) < n_ins)) begin
                if ($urandom_range(0, 99) < 6)
                    d = DELTA_W'($urandom_range(0, 65535));
                else
                    d = DELTA_W'($urandom_range(0, dur_max));
                put_job(JOB_BEAT, 1'b1, d, OWNER_W'($urandom), '0);
                n_ins--;
            end else begin
                put_ticks(1);
                n_tick--;
            end
        end
    endfunction

    // sender: input beats and register writes
    always @(posedge clk or negedge rst_n)
    begin
        job_t j;
        logic nv_in;
        logic nv_cfg;
        if (!rst_n) begin
            in_valid         <= 1'b0;
            cfg_valid        <= 1'b0;
            mode             <= 1'b0;
            duration         <= '0;
            process_id       <= '0;
            ticks_per_second <= TPS_RESET;
            gap_left = 0;
            quiet    = 0;
        end else begin
            if (in_valid && in_ready) begin
                advance_timer_queue(mode, duration, process_id);
                gap_left = cur_gap;
            end
            if (cfg_valid && cfg_ready) begin
                secs_divisor = ticks_per_second;
                gap_left     = cur_gap;
            end
            if (!in_valid && !cfg_valid && replies_due.size() == 0)
                quiet++;
            else
                quiet = 0;
            if (!((in_valid && !in_ready) || (cfg_valid && !cfg_ready))) begin
                nv_in  = 1'b0;
                nv_cfg = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (jobs.size() > 0) begin
                    case (jobs[0].act)
                        JOB_BEAT: begin
                            j = jobs.pop_front();
                            nv_in = 1'b1;
                            mode       <= j.mode;
                            duration   <= j.dur;
                            process_id <= j.pid;
                            cur_gap = j.gap;
                            if (j.hold_rx)
                                hold_asked++;
                        end
                        JOB_CFG: begin
                            if (quiet >= SETTLE) begin
                                j = jobs.pop_front();
                                nv_cfg = 1'b1;
                                ticks_per_second <= j.tps;
                                cur_gap = j.gap;
                            end
                        end
                        JOB_SYNC: begin
                            if (replies_due.size() == 0)
                                void'(jobs.pop_front());
                        end
                        default: ;
                    endcase
                end
                in_valid  <= nv_in;
                cfg_valid <= nv_cfg;
            end
        end
    end

    // receiver: ready pattern and result checks
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left  = 0;
            stall_left = 0;
            calm_left  = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected result beat: kind %0d owner_id %0d last %0d",
                           kind, owner_id, last);
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    if (kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        errors++;
                    end
                    if (owner_id !== want.owner) begin
                        $error("owner_id: expected %0d, got %0d", want.owner, owner_id);
                        errors++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errors++;
                    end
                end
            end
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) < 2)
                    calm_left = $urandom_range(50, 150);
                if (calm_left == 0 && $urandom_range(0, 99) < 25) begin
                    stall_left = idle_span() - 1;
                    out_ready <= 1'b0;
                end else
                    out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        // reset prescaler setting: thirty ticks make no second
        put_job(JOB_BEAT, 1'b1, 16'd0, 8'h00, '0);
        put_job(JOB_BEAT, 1'b1, 16'd3, 8'hA5, '0);
        put_job(JOB_BEAT, 1'b1, 16'd3, 8'h5A, '0);
        put_job(JOB_BEAT, 1'b1, 16'd1, 8'h01, '0);
        put_ticks(30);
        // register lowered below the count: the next tick makes a second,
        // the zero-duration head wakes there and the rest drain after
        put_job(JOB_CFG, 1'b0, '0, '0, 8'd1);
        put_ticks(4);
        // full queue, one refused insert, then sixteen wakes from one tick
        for (int i = 0; i < DEPTH; i++)
            put_job(JOB_BEAT, 1'b1, 16'd1, OWNER_W'(8'h10 + i), '0);
        put_job(JOB_BEAT, 1'b1, 16'hFFFF, 8'hFF, '0);
        put_ticks(2);
        put_job(JOB_BEAT, 1'b1, 16'hFFFF, 8'hFF, '0);
        put_job(JOB_BEAT, 1'b1, 16'd0, 8'h7E, '0);
        put_ticks(1);

        plan_phase(8'd1, 15, 15, 4);
        // sender waits for all results, then a burst against a stalled receiver
        put_job(JOB_SYNC, 1'b0, '0, '0, '0);
        for (int i = 0; i < 8; i++) begin
            put_job(JOB_BEAT, 1'b1, DELTA_W'($urandom_range(0, 6)), OWNER_W'($urandom), '0);
            jobs[jobs.size() - 1].gap = 0;
        end
        jobs[jobs.size() - 8].hold_rx = 1'b1;
        put_ticks(4);
        plan_phase(8'd2, 8, 12, 5);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (jobs.size() != 0 || in_valid || cfg_valid || replies_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && replies_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hdl/dltq_pkg.sv
hdl/dltq_cell.sv
hdl/delta_list_timer_queue_unit.sv
bench/delta_list_timer_queue_unit_tb.sv
